/* design/poll_response_device_tracker_top_assert.svh */
// Assertion macros for the poll/response device tracker checker.
// Relies on clk and rst_n being visible where a macro is used.
`ifndef POLL_RESPONSE_DEVICE_TRACKER_TOP_ASSERT_SVH
`define POLL_RESPONSE_DEVICE_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PRDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prdt check failed");

// Next-cycle implication.
`define PRDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prdt check failed");

`endif

/* design/prdt_pkg.sv */
// Types and constants for the poll/response device tracker.
// No dependencies.
package prdt_pkg;

  localparam int SLOT_W   = 5;
  localparam int WINDOW_W = 24;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd10000000;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_POLL  = 2'd1;
  localparam logic [1:0] KIND_RESP  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [63:0] time_us;
    logic [6:0]  frame_length;
    logic        has_network_header;
    logic [15:0] pan_id;
    logic [15:0] network_source;
    logic [15:0] network_dest;
    logic [1:0]  frame_kind;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   source_slot;
    logic                source_found;
    logic [SLOT_W-1:0]   target_slot;
    logic                target_found;
    logic                response_matched;
    logic [WINDOW_W-1:0] response_delay_us;
    logic [31:0]         source_frame_count;
    logic [31:0]         overflow_count;
  } out_res_t;

  typedef struct packed {
    logic [15:0] pan;
    logic [15:0] address;
    logic [31:0] frames;
    logic [31:0] requests;
    logic [31:0] responses;
    logic [31:0] matched;
    logic [31:0] intervals;
    logic [63:0] last_request;
    logic [63:0] interval_sum;
    logic [63:0] delay_sum;
    logic [6:0]  request_size;
    logic [6:0]  response_size;
    logic        is_poller;
    logic        is_responder;
    logic        awaiting;
  } entry_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

/* design/poll_response_device_tracker_top.sv */
// Poll/response device tracker: device table in one RAM, scanned per lookup.
// Clear and headerless frames skip the table; other frames scan the RAM one entry
// a cycle for the source lookup, and polls then do a second scan for the target.
// One request at a time; busy is high until the result strobe. Results cannot
// be stalled. Synchronous reset empties the table at once via per-entry valid bits.
module poll_response_device_tracker_top import prdt_pkg::*; #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  in_req_t             in_req,
  output logic                busy,
  input  logic                cfg_we,
  input  logic [WINDOW_W-1:0] cfg_wdata,
  output logic                out_strobe,
  output out_res_t            out_res
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_DISP, S_SCAN, S_READ, S_MOD, S_OUT} state_t;

  state_t                   state_r;
  in_req_t                  req_r;
  logic [WINDOW_W-1:0]      window_r;
  logic [31:0]              overflow_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     tgt_r;
  logic [CW-1:0]            iss_r;
  logic                     chk_r;
  logic [AW-1:0]            chk_idx_r;
  logic                     free_seen_r;
  logic [AW-1:0]            free_idx_r;
  logic [AW-1:0]            slot_r;
  logic                     src_found_r;
  logic [AW-1:0]            src_slot_r;
  logic [31:0]              frames_out_r;
  logic                     matched_r;
  logic [WINDOW_W-1:0]      delay_r;
  logic                     tgt_found_r;
  logic [AW-1:0]            tgt_slot_r;
  logic                     out_strobe_r;
  out_res_t                 out_res_r;

  entry_t        ram_rdata;
  entry_t        cur;
  entry_t        entry_nxt;
  logic [AW-1:0] ram_raddr;
  logic          ram_we;
  logic [15:0]   key_addr;
  logic          hit;
  logic          is_free;
  logic [63:0]   diff;
  logic          match_ok;

  prdt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (entry_nxt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_addr  = tgt_r ? req_r.network_dest : req_r.network_source;
  assign ram_raddr = (state_r == S_SCAN) ? iss_r[AW-1:0] : slot_r;
  assign ram_we    = (state_r == S_MOD);

  assign hit     = chk_r && valid_r[chk_idx_r] && (ram_rdata.pan == req_r.pan_id)
                   && (ram_rdata.address == key_addr);
  assign is_free = chk_r && !valid_r[chk_idx_r];

  // Treat a slot without its valid bit as a blank entry for this key.
  always_comb begin
    if (valid_r[slot_r]) begin
      cur = ram_rdata;
    end else begin
      cur         = '0;
      cur.pan     = req_r.pan_id;
      cur.address = key_addr;
    end
  end

  assign diff     = req_r.time_us - cur.last_request;
  assign match_ok = (req_r.frame_kind == KIND_RESP) && cur.awaiting
                    && (cur.last_request != 64'd0) && (req_r.time_us > cur.last_request)
                    && (diff < {40'd0, window_r});

  always_comb begin
    entry_nxt = cur;
    if (!tgt_r) begin
      entry_nxt.frames = sat_inc32(cur.frames);
      if (req_r.frame_kind == KIND_POLL) begin
        entry_nxt.is_poller = 1'b1;
      end else if (req_r.frame_kind == KIND_RESP) begin
        entry_nxt.is_responder  = 1'b1;
        entry_nxt.responses     = sat_inc32(cur.responses);
        entry_nxt.response_size = req_r.frame_length;
        if (match_ok) begin
          entry_nxt.delay_sum = sat_add64(cur.delay_sum, diff);
          entry_nxt.matched   = sat_inc32(cur.matched);
          entry_nxt.awaiting  = 1'b0;
        end
      end
    end else begin
      if (cur.last_request != 64'd0) begin
        entry_nxt.interval_sum = sat_add64(cur.interval_sum, diff);
        entry_nxt.intervals    = sat_inc32(cur.intervals);
      end
      entry_nxt.last_request = req_r.time_us;
      entry_nxt.awaiting     = 1'b1;
      entry_nxt.request_size = req_r.frame_length;
      entry_nxt.requests     = sat_inc32(cur.requests);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_r     <= WINDOW_RESET;
      overflow_r   <= '0;
      valid_r      <= '0;
      chk_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r       <= in_req;
            src_found_r <= 1'b0;
            src_slot_r  <= '0;
            frames_out_r <= '0;
            matched_r   <= 1'b0;
            delay_r     <= '0;
            tgt_found_r <= 1'b0;
            tgt_slot_r  <= '0;
            state_r     <= S_DISP;
          end
        end
        S_DISP: begin
          tgt_r       <= 1'b0;
          iss_r       <= '0;
          chk_r       <= 1'b0;
          free_seen_r <= 1'b0;
          if (req_r.func == FUNC_CLEAR) begin
            valid_r    <= '0;
            overflow_r <= '0;
            state_r    <= S_OUT;
          end else if (!req_r.has_network_header) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss_r != CNT_END) begin
            iss_r <= iss_r + CW'(1);
          end
          chk_r     <= (iss_r != CNT_END);
          chk_idx_r <= iss_r[AW-1:0];
          if (is_free && !free_seen_r) begin
            free_seen_r <= 1'b1;
            free_idx_r  <= chk_idx_r;
          end
          if (hit) begin
            slot_r  <= chk_idx_r;
            chk_r   <= 1'b0;
            state_r <= S_READ;
          end else if (chk_r && chk_idx_r == LAST_IDX) begin
            chk_r <= 1'b0;
            if (free_seen_r || is_free) begin
              slot_r  <= free_seen_r ? free_idx_r : chk_idx_r;
              state_r <= S_READ;
            end else begin
              // Table full: count it and move on without an entry.
              overflow_r <= sat_inc32(overflow_r);
              if (!tgt_r && req_r.frame_kind == KIND_POLL) begin
                tgt_r       <= 1'b1;
                iss_r       <= '0;
                free_seen_r <= 1'b0;
              end else begin
                state_r <= S_OUT;
              end
            end
          end
        end
        S_READ: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          valid_r[slot_r] <= 1'b1;
          if (!tgt_r) begin
            src_found_r  <= 1'b1;
            src_slot_r   <= slot_r;
            frames_out_r <= entry_nxt.frames;
            matched_r    <= match_ok;
            delay_r      <= match_ok ? diff[WINDOW_W-1:0] : '0;
            if (req_r.frame_kind == KIND_POLL) begin
              tgt_r       <= 1'b1;
              iss_r       <= '0;
              chk_r       <= 1'b0;
              free_seen_r <= 1'b0;
              state_r     <= S_SCAN;
            end else begin
              state_r <= S_OUT;
            end
          end else begin
            tgt_found_r <= 1'b1;
            tgt_slot_r  <= slot_r;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          out_strobe_r                 <= 1'b1;
          out_res_r.source_slot        <= SLOT_W'(src_slot_r);
          out_res_r.source_found       <= src_found_r;
          out_res_r.target_slot        <= SLOT_W'(tgt_slot_r);
          out_res_r.target_found       <= tgt_found_r;
          out_res_r.response_matched   <= matched_r;
          out_res_r.response_delay_us  <= delay_r;
          out_res_r.source_frame_count <= frames_out_r;
          out_res_r.overflow_count     <= overflow_r;
          state_r                      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

/* design/prdt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/prdt_checker.sv */
// Port-level checks for the poll/response device tracker, bound to the top.
// Depends on prdt_pkg and poll_response_device_tracker_top_assert.svh.
`include "poll_response_device_tracker_top_assert.svh"

module prdt_checker import prdt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input in_req_t             in_req,
  input logic                busy,
  input logic                cfg_we,
  input logic [WINDOW_W-1:0] cfg_wdata,
  input logic                out_strobe,
  input out_res_t            out_res
);

  `PRDT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `PRDT_ASSERT_IMP(a_strobe_idle, out_strobe, !busy)
  `PRDT_ASSERT_IMP(a_no_src_zero, out_strobe && !out_res.source_found,
                   out_res.source_slot == '0 && out_res.source_frame_count == 32'd0)
  `PRDT_ASSERT_IMP(a_delay_pair, out_strobe && !out_res.response_matched,
                   out_res.response_delay_us == '0)
  `PRDT_ASSERT_IMP(a_match_src, out_strobe && out_res.response_matched,
                   out_res.source_found && out_res.response_delay_us != '0)

endmodule

bind poll_response_device_tracker_top prdt_checker u_prdt_checker (.*);
